FILE: rtl/wpw_pkg.sv
// Package for the windowed pixel writer with shade palette.
// Holds screen geometry, field widths, color masks and register index codes.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package wpw_pkg;

   localparam int unsigned SCREEN_WIDTH  = 320;
   localparam int unsigned SCREEN_HEIGHT = 240;

   localparam int unsigned COLOR_W = 16;
   localparam int unsigned PAIR_W  = 8;
   localparam int unsigned ADDR_W  = 17;
   localparam int unsigned COL_W   = 9;
   localparam int unsigned ROW_W   = 9;
   localparam int unsigned EDGE_W  = 8;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [COLOR_W-1:0] MONO_MASK  = 16'h8410;
   localparam logic [COLOR_W-1:0] COLOR_ONES = 16'hFFFF;
   localparam logic [COLOR_W-1:0] RED_MASK   = 16'hF800;
   localparam logic [COLOR_W-1:0] GREEN_MASK = 16'h07E0;
   localparam logic [COLOR_W-1:0] BLUE_MASK  = 16'h001F;
   localparam logic [3:0]         SHADE_MAX  = 4'd15;
   localparam logic [ROW_W-1:0]   ROW_LIMIT  = 9'd511;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WINDOW_LEFT   = 3'd0,
      CSR_WINDOW_TOP    = 3'd1,
      CSR_WINDOW_RIGHT  = 3'd2,
      CSR_WINDOW_BOTTOM = 3'd3,
      CSR_FORE_COLOR    = 3'd4,
      CSR_BACK_COLOR    = 3'd5,
      CSR_MONO_ENABLE   = 3'd6
   } csr_index_type;

endpackage

`default_nettype wire

FILE: rtl/wpw_if.sv
// Valid/ready channel interfaces for the request items and the write results.
// Depends on wpw_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface wpw_req_if import wpw_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               mode;
   logic [COLOR_W-1:0] pixel_color;
   logic [PAIR_W-1:0]  shade_pair;

   modport source (output valid, output mode, output pixel_color, output shade_pair,
                   input ready);
   modport sink   (input valid, input mode, input pixel_color, input shade_pair,
                   output ready);
endinterface

interface wpw_rsp_if import wpw_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               write_enable;
   logic [ADDR_W-1:0]  write_address;
   logic [COLOR_W-1:0] write_color;
   logic               past_window;
   logic               last_of_item;

   modport source (output valid, output write_enable, output write_address,
                   output write_color, output past_window, output last_of_item,
                   input ready);
   modport sink   (input valid, input write_enable, input write_address,
                   input write_color, input past_window, input last_of_item,
                   output ready);
endinterface

`default_nettype wire

FILE: rtl/windowed_pixel_writer_with_shade_palette_top.sv
// Top level of the windowed pixel writer with shade palette.
// Depends on wpw_pkg and on the channel interfaces in wpw_if.sv.
//
//   channel  direction  content
//   req_if   in         mode, pixel_color, shade_pair
//   rsp_if   out        write_enable, write_address, write_color, past_window, last_of_item
//   csr_*    in         csr_we, csr_index, csr_wdata
//
// A direct pixel gives one result and a shade pair two, one result per cycle while the
// single result register is free to take the next pixel.
// Each result is computed from the item held in the input register and kept in the result register.
// Reset is synchronous and clears the handshake state and the window position.
// A stalled result holds the input register, and the next transaction waits.
`timescale 1ns / 1ps
`default_nettype none

module windowed_pixel_writer_with_shade_palette_top import wpw_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   wpw_req_if.sink                     req_if,
   wpw_rsp_if.source                   rsp_if,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam logic [ADDR_W-1:0] SCREEN_W_A = ADDR_W'(SCREEN_WIDTH);
   localparam logic [10:0]       SCREEN_W_C = 11'(SCREEN_WIDTH);
   localparam logic [10:0]       SCREEN_H_C = 11'(SCREEN_HEIGHT);
   localparam logic [21:0]       RECIP_15   = 22'd2185;

   function automatic logic [5:0] blend(input logic [5:0] f, input logic [5:0] b,
                                        input logic [3:0] s);
      logic [9:0]  sum;
      logic [21:0] scaled;
      sum    = 10'(f) * 10'(s) + 10'(b) * 10'(SHADE_MAX - s);
      scaled = 22'(sum) * RECIP_15;
      return scaled[20:15];
   endfunction

   logic [COL_W-1:0]   window_left_ff, window_right_ff;
   logic [EDGE_W-1:0]  window_top_ff, window_bottom_ff;
   logic [COLOR_W-1:0] fore_color_ff, back_color_ff;
   logic               mono_enable_ff;
   logic [COL_W-1:0]   cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]   cur_row_ff, cur_row_in;

   logic               hold_valid_ff, hold_valid_in;
   logic               hold_mode_ff;
   logic [COLOR_W-1:0] hold_pixel_ff;
   logic [PAIR_W-1:0]  hold_pair_ff;
   logic               hold_phase_ff, hold_phase_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_we_ff;
   logic [ADDR_W-1:0]  rsp_addr_ff;
   logic [COLOR_W-1:0] rsp_color_ff;
   logic               rsp_past_ff;
   logic               rsp_last_ff;

   logic               wr_left, wr_top, wr_right, wr_bottom;
   logic               wr_fore, wr_back, wr_mono, wr_window;

   logic               out_free, issue, hold_last, hold_done, req_take;
   logic [3:0]         shade;
   logic [5:0]         red_q, green_q, blue_q;
   logic [COLOR_W-1:0] shade_color, raw_color, final_color;
   logic               past, in_window;
   logic [ADDR_W-1:0]  pix_addr;
   logic [COL_W:0]     col_step;

   always_comb begin
      wr_left   = 1'b0;
      wr_top    = 1'b0;
      wr_right  = 1'b0;
      wr_bottom = 1'b0;
      wr_fore   = 1'b0;
      wr_back   = 1'b0;
      wr_mono   = 1'b0;
      wr_window = 1'b0;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_WINDOW_LEFT:   wr_left   = 1'b1;
            CSR_WINDOW_TOP:    wr_top    = 1'b1;
            CSR_WINDOW_RIGHT:  wr_right  = 1'b1;
            CSR_WINDOW_BOTTOM: wr_bottom = 1'b1;
            CSR_FORE_COLOR:    wr_fore   = 1'b1;
            CSR_BACK_COLOR:    wr_back   = 1'b1;
            CSR_MONO_ENABLE:   wr_mono   = 1'b1;
            default:           wr_window = 1'b0;
         endcase
         unique case (csr_index_type'(csr_index)) inside
            CSR_WINDOW_LEFT, CSR_WINDOW_TOP, CSR_WINDOW_RIGHT, CSR_WINDOW_BOTTOM:
               wr_window = 1'b1;
            default: wr_window = 1'b0;
         endcase
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign issue     = hold_valid_ff && out_free;
   assign hold_last = !hold_mode_ff || hold_phase_ff;
   assign hold_done = issue && hold_last;
   assign req_take  = req_if.valid && req_if.ready;
   assign req_if.ready = !hold_valid_ff || hold_done;

   assign shade = hold_phase_ff ? hold_pair_ff[3:0] : hold_pair_ff[7:4];
   assign red_q   = blend({1'b0, fore_color_ff[15:11]}, {1'b0, back_color_ff[15:11]}, shade);
   assign green_q = blend(fore_color_ff[10:5], back_color_ff[10:5], shade);
   assign blue_q  = blend({1'b0, fore_color_ff[4:0]}, {1'b0, back_color_ff[4:0]}, shade);
   assign shade_color = (({red_q[4:0], 11'd0}) & RED_MASK)
                      | (({5'd0, green_q, 5'd0}) & GREEN_MASK)
                      | (({11'd0, blue_q[4:0]}) & BLUE_MASK);
   assign raw_color   = hold_mode_ff ? shade_color : hold_pixel_ff;
   assign final_color = !mono_enable_ff ? raw_color
                      : ((raw_color & MONO_MASK) != '0) ? COLOR_ONES : '0;

   assign past      = cur_row_ff > {1'b0, window_bottom_ff};
   assign in_window = (cur_col_ff <= window_right_ff) && !past
                   && ({2'b0, cur_col_ff} < SCREEN_W_C) && ({2'b0, cur_row_ff} < SCREEN_H_C);
   assign pix_addr = ADDR_W'(cur_col_ff) + ADDR_W'(cur_row_ff) * SCREEN_W_A;
   assign col_step = {1'b0, cur_col_ff} + 10'd1;

   always_comb begin
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      if (wr_window) begin
         cur_col_in = wr_left ? csr_wdata[COL_W-1:0] : window_left_ff;
         cur_row_in = wr_top ? {1'b0, csr_wdata[EDGE_W-1:0]} : {1'b0, window_top_ff};
      end else if (issue) begin
         if (col_step > {1'b0, window_right_ff}) begin
            cur_col_in = window_left_ff;
            if (cur_row_ff < ROW_LIMIT) begin
               cur_row_in = cur_row_ff + 9'd1;
            end
         end else begin
            cur_col_in = col_step[COL_W-1:0];
         end
      end
   end

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_phase_in = hold_phase_ff;
      if (req_take) begin
         hold_valid_in = 1'b1;
         hold_phase_in = 1'b0;
      end else if (hold_done) begin
         hold_valid_in = 1'b0;
      end else if (issue) begin
         hold_phase_in = 1'b1;
      end
      rsp_valid_in = issue || (rsp_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_left_ff   <= '0;
         window_top_ff    <= '0;
         window_right_ff  <= 9'd319;
         window_bottom_ff <= 8'd239;
         fore_color_ff    <= COLOR_ONES;
         back_color_ff    <= '0;
         mono_enable_ff   <= 1'b0;
         cur_col_ff       <= '0;
         cur_row_ff       <= '0;
         hold_valid_ff    <= 1'b0;
         hold_phase_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (wr_left)   window_left_ff   <= csr_wdata[COL_W-1:0];
         if (wr_top)    window_top_ff    <= csr_wdata[EDGE_W-1:0];
         if (wr_right)  window_right_ff  <= csr_wdata[COL_W-1:0];
         if (wr_bottom) window_bottom_ff <= csr_wdata[EDGE_W-1:0];
         if (wr_fore)   fore_color_ff    <= csr_wdata[COLOR_W-1:0];
         if (wr_back)   back_color_ff    <= csr_wdata[COLOR_W-1:0];
         if (wr_mono)   mono_enable_ff   <= csr_wdata[0];
         cur_col_ff    <= cur_col_in;
         cur_row_ff    <= cur_row_in;
         hold_valid_ff <= hold_valid_in;
         hold_phase_ff <= hold_phase_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         hold_mode_ff  <= req_if.mode;
         hold_pixel_ff <= req_if.pixel_color;
         hold_pair_ff  <= req_if.shade_pair;
      end
      if (issue) begin
         rsp_we_ff    <= in_window;
         rsp_addr_ff  <= in_window ? pix_addr : '0;
         rsp_color_ff <= in_window ? final_color : '0;
         rsp_past_ff  <= past;
         rsp_last_ff  <= hold_last;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.write_enable  = rsp_we_ff;
   assign rsp_if.write_address = rsp_addr_ff;
   assign rsp_if.write_color   = rsp_color_ff;
   assign rsp_if.past_window   = rsp_past_ff;
   assign rsp_if.last_of_item  = rsp_last_ff;

endmodule

`default_nettype wire

FILE: rtl/wpw_checker.sv
// Port-level checker for the windowed pixel writer, with its bind statement.
// Depends on wpw_pkg and on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module wpw_checker import wpw_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic               rsp_write_enable,
   input wire logic [ADDR_W-1:0]  rsp_write_address,
   input wire logic [COLOR_W-1:0] rsp_write_color,
   input wire logic               rsp_past_window,
   input wire logic               rsp_last_of_item
);

   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("Result valid right after reset.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_enable |-> !rsp_past_window)
      else $error("A pixel beyond the last row is written.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_enable |-> rsp_write_address == '0 && rsp_write_color == '0)
      else $error("A suppressed pixel carries an address or a color.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_write_enable)
         && $stable(rsp_write_address) && $stable(rsp_write_color)
         && $stable(rsp_past_window) && $stable(rsp_last_of_item))
      else $error("A stalled result transaction changed.");

endmodule

bind windowed_pixel_writer_with_shade_palette_top wpw_checker u_wpw_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_write_enable  (rsp_if.write_enable),
   .rsp_write_address (rsp_if.write_address),
   .rsp_write_color   (rsp_if.write_color),
   .rsp_past_window   (rsp_if.past_window),
   .rsp_last_of_item  (rsp_if.last_of_item)
);

`default_nettype wire

FILE: bench/tb_windowed_pixel_writer_with_shade_palette_top.sv
// Testbench for windowed_pixel_writer_with_shade_palette_top: a directed table, then random
// phases under varied window and palette settings, writes checked by table or predictor.
// Depends on wpw_pkg and the channel interfaces in wpw_if.sv.
`timescale 1ns / 1ps

module tb_windowed_pixel_writer_with_shade_palette_top;
   import wpw_pkg::*;

   localparam logic                   MODE_DIRECT    = 1'b0;
   localparam logic                   MODE_SHADES    = 1'b1;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED     = 3'd7;
   localparam int                     HOLD_CYCLES    = 80;
   localparam int                     WATCHDOG_LIMIT = 1000;
   localparam int                     SETTLE_CYCLES  = 4;
   localparam int                     PHASES         = 12;
   localparam int                     PHASE_ITEMS    = 62;
   localparam int                     SATURATE_ITEMS = 170;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [COLOR_W-1:0] color;
      logic              past;
      logic              last;
   } pixel_write_type;

   localparam pixel_write_type NO_WRITE = '0;

   typedef struct {
      bit                     is_csr;
      logic [CSR_INDEX_W-1:0] idx;
      logic [CSR_DATA_W-1:0]  data;
      logic                   mode;
      logic [COLOR_W-1:0]     pix;
      logic [PAIR_W-1:0]      pair;
      bit                     typed;
      pixel_write_type        want0;
      pixel_write_type        want1;
   } directed_step_type;

   logic clock;
   logic reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   wpw_req_if req_if ();
   wpw_rsp_if rsp_if ();

   windowed_pixel_writer_with_shade_palette_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [COL_W-1:0]   win_left   = '0;
   logic [EDGE_W-1:0]  win_top    = '0;
   logic [COL_W-1:0]   win_right  = 9'd319;
   logic [EDGE_W-1:0]  win_bottom = 8'd239;
   logic [COLOR_W-1:0] fore_color = COLOR_ONES;
   logic [COLOR_W-1:0] back_color = '0;
   bit                 mono_on    = 1'b0;
   logic [COL_W-1:0]   pos_col    = '0;
   logic [ROW_W-1:0]   pos_row    = '0;

   pixel_write_type   pending_writes[$];
   directed_step_type steps[$];
   int             mismatches = 0;
   bit             gaps_on = 1'b1;
   bit             hold_toggle = 1'b0;
   bit             hold_seen = 1'b0;
   int             hold_left = 0;
   int             quiet_cycles = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [COLOR_W-1:0] shade_to_color(logic [3:0] s);
      int sh, inv, r, g, b;
      sh  = int'(s);
      inv = int'(SHADE_MAX) - sh;
      r = (int'(fore_color[15:11]) * sh + int'(back_color[15:11]) * inv) / int'(SHADE_MAX);
      g = (int'(fore_color[10:5]) * sh + int'(back_color[10:5]) * inv) / int'(SHADE_MAX);
      b = (int'(fore_color[4:0]) * sh + int'(back_color[4:0]) * inv) / int'(SHADE_MAX);
      return {5'(r), 6'(g), 5'(b)};
   endfunction

   // Produces the write for the current position and steps the position.
   function automatic pixel_write_type next_write(logic [COLOR_W-1:0] color, logic last);
      pixel_write_type    w;
      logic [COLOR_W-1:0] c;
      logic               past, in_window;
      int                 nxt;
      past      = pos_row > {1'b0, win_bottom};
      in_window = (pos_col <= win_right) && !past && (pos_col < SCREEN_WIDTH) &&
                  (pos_row < SCREEN_HEIGHT);
      c = color;
      if (mono_on) c = ((color & MONO_MASK) != '0) ? COLOR_ONES : '0;
      w.we    = in_window;
      w.addr  = in_window ? ADDR_W'(int'(pos_col) + int'(pos_row) * int'(SCREEN_WIDTH)) : '0;
      w.color = in_window ? c : '0;
      w.past  = past;
      w.last  = last;
      nxt = int'(pos_col) + 1;
      if (nxt > int'(win_right)) begin
         pos_col = win_left;
         if (pos_row < ROW_LIMIT) pos_row = pos_row + 1'b1;
      end else begin
         pos_col = COL_W'(nxt);
      end
      return w;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   function automatic void add_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      directed_step_type s;
      s.is_csr = 1'b1;
      s.idx    = idx;
      s.data   = data;
      s.mode   = MODE_DIRECT;
      s.pix    = '0;
      s.pair   = '0;
      s.typed  = 1'b0;
      s.want0  = NO_WRITE;
      s.want1  = NO_WRITE;
      steps.push_back(s);
   endfunction

   function automatic void add_item(logic mode, logic [COLOR_W-1:0] pix, logic [PAIR_W-1:0] pair,
                                    bit typed, pixel_write_type want0,
                                    pixel_write_type want1);
      directed_step_type s;
      s.is_csr = 1'b0;
      s.idx    = '0;
      s.data   = '0;
      s.mode   = mode;
      s.pix    = pix;
      s.pair   = pair;
      s.typed  = typed;
      s.want0  = want0;
      s.want1  = want1;
      steps.push_back(s);
   endfunction

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_WINDOW_LEFT:   win_left   = data[COL_W-1:0];
         CSR_WINDOW_TOP:    win_top    = data[EDGE_W-1:0];
         CSR_WINDOW_RIGHT:  win_right  = data[COL_W-1:0];
         CSR_WINDOW_BOTTOM: win_bottom = data[EDGE_W-1:0];
         CSR_FORE_COLOR:    fore_color = data;
         CSR_BACK_COLOR:    back_color = data;
         CSR_MONO_ENABLE:   mono_on    = data[0];
         default: ;
      endcase
      if (idx == CSR_WINDOW_LEFT || idx == CSR_WINDOW_TOP || idx == CSR_WINDOW_RIGHT ||
          idx == CSR_WINDOW_BOTTOM) begin
         pos_col = win_left;
         pos_row = {1'b0, win_top};
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_item(input logic mode, input logic [COLOR_W-1:0] pix,
                            input logic [PAIR_W-1:0] pair, input bit typed,
                            input pixel_write_type want0, input pixel_write_type want1);
      pixel_write_type p0, p1;
      while (gaps_on && $urandom_range(0, 99) < 16) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.mode        <= mode;
      req_if.pixel_color <= pix;
      req_if.shade_pair  <= pair;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (mode == MODE_DIRECT) begin
         p0 = next_write(pix, 1'b1);
         pending_writes.push_back(typed ? want0 : p0);
      end else begin
         p0 = next_write(shade_to_color(pair[7:4]), 1'b0);
         p1 = next_write(shade_to_color(pair[3:0]), 1'b1);
         pending_writes.push_back(typed ? want0 : p0);
         pending_writes.push_back(typed ? want1 : p1);
      end
   endtask

   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen    <= hold_toggle;
         hold_left    <= HOLD_CYCLES;
         rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= !gaps_on || ($urandom_range(0, 99) >= 16);
      end
   end

   always @(posedge clock) begin
      pixel_write_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_writes.size() == 0) begin
            $display("%0t: unexpected write: expected none, actual address %0h color %0h",
                     $time, rsp_if.write_address, rsp_if.write_color);
            mismatches++;
         end else begin
            want = pending_writes.pop_front();
            check_field("write_enable", want.we, rsp_if.write_enable);
            check_field("write_address", want.addr, rsp_if.write_address);
            check_field("write_color", want.color, rsp_if.write_color);
            check_field("past_window", want.past, rsp_if.past_window);
            check_field("last_of_item", want.last, rsp_if.last_of_item);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int               n, shape;
      logic             m;
      bit               mono;
      logic [COL_W-1:0] l, r;
      logic [EDGE_W-1:0] t, b;
      logic [COLOR_W-1:0] fg, bg;

      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.mode        = MODE_DIRECT;
      req_if.pixel_color = '0;
      req_if.shade_pair  = '0;
      rsp_if.ready       = 1'b0;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;

      // Reset palette and full-screen window.
      add_item(MODE_DIRECT, 16'h0000, 8'h00, 1'b1,
               pixel_write_type'{1'b1, 17'd0, 16'h0000, 1'b0, 1'b1}, NO_WRITE);
      add_item(MODE_DIRECT, 16'hFFFF, 8'hFF, 1'b1,
               pixel_write_type'{1'b1, 17'd1, 16'hFFFF, 1'b0, 1'b1}, NO_WRITE);
      add_item(MODE_SHADES, 16'hFFFF, 8'hF0, 1'b1,
               pixel_write_type'{1'b1, 17'd2, 16'hFFFF, 1'b0, 1'b0},
               pixel_write_type'{1'b1, 17'd3, 16'h0000, 1'b0, 1'b1});
      add_item(MODE_SHADES, 16'h0000, 8'h0F, 1'b1,
               pixel_write_type'{1'b1, 17'd4, 16'h0000, 1'b0, 1'b0},
               pixel_write_type'{1'b1, 17'd5, 16'hFFFF, 1'b0, 1'b1});
      add_csr(CSR_FORE_COLOR, 16'hF81F);
      add_csr(CSR_BACK_COLOR, 16'h07E0);
      add_item(MODE_SHADES, 16'h5555, 8'h5A, 1'b0, NO_WRITE, NO_WRITE);
      add_item(MODE_SHADES, 16'hAAAA, 8'h87, 1'b0, NO_WRITE, NO_WRITE);
      // An index past the register list must leave the position alone.
      add_csr(CSR_UNUSED, 16'hFFFF);
      add_item(MODE_DIRECT, 16'h1234, 8'hC3, 1'b0, NO_WRITE, NO_WRITE);
      add_csr(CSR_MONO_ENABLE, 16'h0001);
      add_item(MODE_DIRECT, 16'h8000, 8'h00, 1'b0, NO_WRITE, NO_WRITE);
      add_item(MODE_DIRECT, 16'h7BEF, 8'h00, 1'b0, NO_WRITE, NO_WRITE);
      add_item(MODE_SHADES, 16'h0000, 8'h3C, 1'b0, NO_WRITE, NO_WRITE);
      add_csr(CSR_MONO_ENABLE, 16'hFFFE);
      // Bottom-right corner of the screen, running past the last row.
      add_csr(CSR_WINDOW_LEFT, 16'd318);
      add_csr(CSR_WINDOW_TOP, 16'd238);
      add_csr(CSR_WINDOW_RIGHT, 16'd319);
      add_csr(CSR_WINDOW_BOTTOM, 16'd239);
      add_item(MODE_SHADES, 16'h0000, 8'hFF, 1'b0, NO_WRITE, NO_WRITE);
      add_item(MODE_SHADES, 16'hFFFF, 8'h00, 1'b0, NO_WRITE, NO_WRITE);
      add_item(MODE_DIRECT, 16'hABCD, 8'h96, 1'b0, NO_WRITE, NO_WRITE);
      add_item(MODE_SHADES, 16'h6969, 8'h12, 1'b0, NO_WRITE, NO_WRITE);
      // Window that reaches off the right and bottom of the screen.
      add_csr(CSR_WINDOW_LEFT, 16'd316);
      add_csr(CSR_WINDOW_TOP, 16'd239);
      add_csr(CSR_WINDOW_RIGHT, 16'd323);
      add_csr(CSR_WINDOW_BOTTOM, 16'd241);
      add_item(MODE_SHADES, 16'h0001, 8'h1E, 1'b0, NO_WRITE, NO_WRITE);
      add_item(MODE_SHADES, 16'h0002, 8'h2D, 1'b0, NO_WRITE, NO_WRITE);
      add_item(MODE_SHADES, 16'h0004, 8'h4B, 1'b0, NO_WRITE, NO_WRITE);
      add_item(MODE_SHADES, 16'h0008, 8'h87, 1'b0, NO_WRITE, NO_WRITE);
      add_item(MODE_SHADES, 16'h0010, 8'hE1, 1'b0, NO_WRITE, NO_WRITE);
      // Left edge beyond the right edge, with unused upper data bits set.
      add_csr(CSR_WINDOW_LEFT, 16'hFE05);
      add_csr(CSR_WINDOW_RIGHT, 16'hFE02);
      add_csr(CSR_WINDOW_TOP, 16'hFF00);
      add_csr(CSR_WINDOW_BOTTOM, 16'h0003);
      add_item(MODE_DIRECT, 16'hF800, 8'h11, 1'b0, NO_WRITE, NO_WRITE);
      add_item(MODE_DIRECT, 16'h07E0, 8'h22, 1'b0, NO_WRITE, NO_WRITE);
      add_item(MODE_DIRECT, 16'h001F, 8'h44, 1'b0, NO_WRITE, NO_WRITE);
      add_item(MODE_SHADES, 16'h8410, 8'h88, 1'b0, NO_WRITE, NO_WRITE);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (steps[i]) begin
         if (steps[i].is_csr) begin
            wait_idle();
            csr_write(steps[i].idx, steps[i].data);
         end else begin
            send_item(steps[i].mode, steps[i].pix, steps[i].pair, steps[i].typed,
                      steps[i].want0, steps[i].want1);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         shape = $urandom_range(0, 3);
         l = COL_W'($urandom_range(0, 319));
         t = EDGE_W'($urandom_range(0, 239));
         case (shape)
            0: begin
               r = l + COL_W'($urandom_range(0, 7));
               b = t + EDGE_W'($urandom_range(0, 3));
            end
            1: begin
               l = COL_W'($urandom);
               r = COL_W'($urandom);
               t = EDGE_W'($urandom);
               b = EDGE_W'($urandom);
            end
            2: begin
               r = COL_W'($urandom_range(0, int'(l)));
               b = t + EDGE_W'($urandom_range(0, 7));
            end
            default: begin
               l = COL_W'($urandom_range(300, 319));
               r = l + COL_W'($urandom_range(0, 30));
               t = EDGE_W'($urandom_range(230, 239));
               b = t + EDGE_W'($urandom_range(0, 16));
            end
         endcase
         fg   = COLOR_W'($urandom);
         bg   = COLOR_W'($urandom);
         mono = ($urandom_range(0, 2) == 0);
         if (p == 0) begin
            l = '0;
            t = '0;
            r = 9'd319;
            b = 8'd239;
         end
         if (p == 1) begin
            l  = '1;
            t  = '1;
            r  = '1;
            b  = '1;
            fg = '0;
            bg = COLOR_ONES;
         end
         // Narrow inverted window so the row count climbs to its limit.
         if (p == 4) begin
            l = 9'd100;
            r = 9'd50;
            t = 8'd200;
            b = 8'd255;
         end
         if (p == 6) mono = 1'b1;
         csr_write(CSR_WINDOW_LEFT, (COLOR_W'($urandom) & ~16'h01FF) | 16'(l));
         csr_write(CSR_WINDOW_TOP, (COLOR_W'($urandom) & ~16'h00FF) | 16'(t));
         csr_write(CSR_WINDOW_RIGHT, (COLOR_W'($urandom) & ~16'h01FF) | 16'(r));
         csr_write(CSR_WINDOW_BOTTOM, (COLOR_W'($urandom) & ~16'h00FF) | 16'(b));
         csr_write(CSR_FORE_COLOR, fg);
         csr_write(CSR_BACK_COLOR, bg);
         csr_write(CSR_MONO_ENABLE, (COLOR_W'($urandom) & ~16'h0001) | 16'(mono));
         if ($urandom_range(0, 3) == 0) csr_write(CSR_UNUSED, COLOR_W'($urandom));
         gaps_on <= (p != 6);
         n = (p == 4) ? SATURATE_ITEMS : PHASE_ITEMS;
         for (int k = 0; k < n; k++) begin
            if (p == 2 && k == 20) hold_toggle <= ~hold_toggle;
            if (p == 8 && k == 30) wait_idle();
            m = (p == 4) ? MODE_SHADES : logic'($urandom_range(0, 1));
            send_item(m, COLOR_W'($urandom), PAIR_W'($urandom), 1'b0, NO_WRITE, NO_WRITE);
         end
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && pending_writes.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
